// File: design/vgd_pkg.sv
// vgd_pkg: shared types, constants and helper functions of the voxel grid downsampler
// used by vgd_ctrl, vgd_datapath and voxel_grid_downsampler; depends on nothing
package vgd_pkg;

  // grid geometry
  localparam int GRID_SIDE  = 32;
  localparam int IDX_W      = 5;
  localparam int LAST_MAX   = GRID_SIDE - 1;
  localparam int ROW_W      = GRID_SIDE;
  localparam int ROW_ADDR_W = 2 * IDX_W;
  localparam int ROWS       = 1 << ROW_ADDR_W;

  // arithmetic widths
  localparam int COORD_W = 32;
  localparam int SCALE_W = 31;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = DIFF_W + SCALE_W + 1;
  localparam int MUL_W   = IDX_W + SCALE_W;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_SIZE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_UNIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_X       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_Y       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_Z       = 3'd7;

  // controller to datapath
  typedef struct packed {
    logic capture;     // latch point minus origin
    logic mul_en;      // register products with inverse unit
    logic snap_en;     // round, clamp, issue bitmap row read
    logic clear_step;  // zero one bitmap row
    logic commit;      // mark node visited and load the result register
  } vgd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;  // clear pointer sits on the last row
    logic hit;         // node already visited
  } vgd_status_t;

  // round a Q32.32 product to nearest (ties up) and clamp to 0 .. last
  function automatic logic [IDX_W-1:0] snap_index(logic signed [PROD_W-1:0] prod,
                                                  logic [IDX_W-1:0] last);
    logic signed [PROD_W-1:0] v;
    logic [PROD_W-33:0]       hi;
    logic [IDX_W-1:0]         lim;
    v   = prod + PROD_W'(64'h0000_0000_8000_0000);
    hi  = v[PROD_W-1:32];
    lim = (32'(last) > 32'(LAST_MAX)) ? IDX_W'(LAST_MAX) : last;
    if (v[PROD_W-1]) begin
      return '0;
    end else if (hi > (PROD_W-32)'(lim)) begin
      return lim;
    end else begin
      return hi[IDX_W-1:0];
    end
  endfunction

endpackage

// File: design/vgd_ctrl.sv
// vgd_ctrl: sequencing state machine of the voxel grid downsampler
// depends on vgd_pkg for the command and status structs
module vgd_ctrl
  import vgd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        new_cloud,
  input  logic        out_stall,
  input  vgd_status_t status,
  output logic        in_stall,
  output logic        out_valid,
  output vgd_cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_SNAP  = 3'd3;
  localparam logic [2:0] S_TEST  = 3'd4;

  logic [2:0] state, state_next;
  logic       pend, pend_next;
  logic       slot_free;

  // result register can take a new transaction this cycle
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    pend_next  = pend;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = pend ? S_MUL : S_IDLE;
          pend_next  = 1'b0;
        end
      end
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          if (new_cloud) begin
            pend_next  = 1'b1;
            state_next = S_CLEAR;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_SNAP;
      end
      S_SNAP: begin
        cmd.snap_en = 1'b1;
        state_next  = S_TEST;
      end
      S_TEST: begin
        if (status.hit) begin
          state_next = S_IDLE;
        end else if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state, pending point and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a result is never loaded over one that is still held
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(out_valid && out_stall))
    else $error("result loaded while output is stalled");

  // a point without new_cloud goes straight to the multiply
  a_accept_mul: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && !new_cloud) |=> state == S_MUL)
    else $error("accepted point did not start the multiply");

  // a clear started by a point resumes that point
  a_clear_resume: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && status.clear_last && pend) |=> state == S_MUL)
    else $error("pending point lost after clear");

  // a commit always sets the output valid
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

endmodule

// File: design/vgd_datapath.sv
// vgd_datapath: configuration registers, snap arithmetic, visited bitmap and result register
// depends on vgd_pkg for widths, command and status structs and snap_index
module vgd_datapath
  import vgd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [COORD_W-1:0]          cfg_data,
  input  vgd_cmd_t                    cmd,
  input  logic signed [COORD_W-1:0]   point_x,
  input  logic signed [COORD_W-1:0]   point_y,
  input  logic signed [COORD_W-1:0]   point_z,
  output vgd_status_t                 status,
  output logic [IDX_W-1:0]            node_x,
  output logic [IDX_W-1:0]            node_y,
  output logic [IDX_W-1:0]            node_z,
  output logic signed [COORD_W-1:0]   grid_x,
  output logic signed [COORD_W-1:0]   grid_y,
  output logic signed [COORD_W-1:0]   grid_z
);

  logic signed [COORD_W-1:0] origin_x, origin_y, origin_z;
  logic [SCALE_W-1:0]        unit_size, inverse_unit;
  logic [IDX_W-1:0]          last_x, last_y, last_z;

  logic signed [DIFF_W-1:0]  diff_x, diff_y, diff_z;
  logic signed [PROD_W-1:0]  prod_x, prod_y, prod_z;
  logic signed [PROD_W-1:0]  inv_ext;
  logic [IDX_W-1:0]          idx_x, idx_y, idx_z;
  logic [IDX_W-1:0]          idx_x_next, idx_y_next, idx_z_next;
  logic [ROW_W-1:0]          row_data;
  logic [ROW_ADDR_W-1:0]     clear_ptr;
  logic [MUL_W-1:0]          step_x, step_y, step_z;

  logic [ROW_W-1:0] vmap [ROWS];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      origin_z     <= '0;
      unit_size    <= SCALE_W'(65536);
      inverse_unit <= SCALE_W'(65536);
      last_x       <= IDX_W'(16);
      last_y       <= IDX_W'(16);
      last_z       <= IDX_W'(16);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:     origin_x     <= $signed(cfg_data);
        CFG_ORIGIN_Y:     origin_y     <= $signed(cfg_data);
        CFG_ORIGIN_Z:     origin_z     <= $signed(cfg_data);
        CFG_UNIT_SIZE:    unit_size    <= cfg_data[SCALE_W-1:0];
        CFG_INVERSE_UNIT: inverse_unit <= cfg_data[SCALE_W-1:0];
        CFG_LAST_X:       last_x       <= cfg_data[IDX_W-1:0];
        CFG_LAST_Y:       last_y       <= cfg_data[IDX_W-1:0];
        CFG_LAST_Z:       last_z       <= cfg_data[IDX_W-1:0];
        default:          ;
      endcase
    end
  end

  // exact offset from the grid origin
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      diff_x <= DIFF_W'(point_x) - DIFF_W'(origin_x);
      diff_y <= DIFF_W'(point_y) - DIFF_W'(origin_y);
      diff_z <= DIFF_W'(point_z) - DIFF_W'(origin_z);
    end
  end

  // scale by the inverse unit into Q32.32
  assign inv_ext = PROD_W'($signed({1'b0, inverse_unit}));

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_x <= PROD_W'(diff_x) * inv_ext;
      prod_y <= PROD_W'(diff_y) * inv_ext;
      prod_z <= PROD_W'(diff_z) * inv_ext;
    end
  end

  // round and clamp per axis
  assign idx_x_next = snap_index(prod_x, last_x);
  assign idx_y_next = snap_index(prod_y, last_y);
  assign idx_z_next = snap_index(prod_z, last_z);

  always_ff @(posedge clk) begin
    if (cmd.snap_en) begin
      idx_x <= idx_x_next;
      idx_y <= idx_y_next;
      idx_z <= idx_z_next;
    end
  end

  // clear pointer walks all rows and wraps back to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_ptr <= '0;
    end else if (cmd.clear_step) begin
      clear_ptr <= clear_ptr + ROW_ADDR_W'(1);
    end
  end

  // visited bitmap, one row per (x, y), one bit per z
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      vmap[clear_ptr] <= '0;
    end else if (cmd.commit) begin
      vmap[{idx_x, idx_y}] <= row_data | (ROW_W'(1) << idx_z);
    end
    if (cmd.snap_en) begin
      row_data <= vmap[{idx_x_next, idx_y_next}];
    end
  end

  assign status.clear_last = (clear_ptr == ROW_ADDR_W'(ROWS - 1));
  assign status.hit        = row_data[idx_z];

  // node coordinates, wrapping modulo 2^32
  assign step_x = MUL_W'(idx_x) * MUL_W'(unit_size);
  assign step_y = MUL_W'(idx_y) * MUL_W'(unit_size);
  assign step_z = MUL_W'(idx_z) * MUL_W'(unit_size);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      node_x <= idx_x;
      node_y <= idx_y;
      node_z <= idx_z;
      grid_x <= origin_x + $signed(step_x[COORD_W-1:0]);
      grid_y <= origin_y + $signed(step_y[COORD_W-1:0]);
      grid_z <= origin_z + $signed(step_z[COORD_W-1:0]);
    end
  end

endmodule

// File: design/voxel_grid_downsampler.sv
// voxel_grid_downsampler: top level, joins the controller and the datapath
// depends on vgd_pkg, vgd_ctrl and vgd_datapath
//
//   channel  signals                                   direction  handshake
//   input    point_x/y/z, new_cloud                    in         in_valid / in_stall
//   output   node_x/y/z, grid_x/y/z                    out        out_valid / out_stall
//   config   cfg_index, cfg_data                       in         cfg_write
//
// a point passes through capture, multiply, round and bitmap row read, and test and
// write back before the next point is accepted
// reset starts a clearing pass over the 1024 bitmap rows; no point is taken during it
// a point with new_cloud runs the same clearing pass before it is processed
// a stalled output holds its result; a new point is still taken and waits in the
// test step only if it produces a result while the previous one is still held
module voxel_grid_downsampler
  import vgd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_W-1:0]        cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic signed [COORD_W-1:0] point_z,
  input  logic                      new_cloud,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [IDX_W-1:0]          node_x,
  output logic [IDX_W-1:0]          node_y,
  output logic [IDX_W-1:0]          node_z,
  output logic signed [COORD_W-1:0] grid_x,
  output logic signed [COORD_W-1:0] grid_y,
  output logic signed [COORD_W-1:0] grid_z
);

  vgd_cmd_t    cmd;
  vgd_status_t status;

  // sequencing
  vgd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .new_cloud (new_cloud),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // arithmetic, bitmap and result register
  vgd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .status    (status),
    .node_x    (node_x),
    .node_y    (node_y),
    .node_z    (node_z),
    .grid_x    (grid_x),
    .grid_y    (grid_y),
    .grid_z    (grid_z)
  );

endmodule
